/* src/fnle_pkg.sv */
package fnle_pkg;

  // Field widths
  localparam int COORD_W    = 11;
  localparam int PIX_W      = 8;
  localparam int LEVEL_W    = 17;
  localparam int SUM_W      = 33;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Sum of three squared 8-bit differences, and the Q18.16 radicand built from it
  localparam int SUMSQ_W = 18;
  localparam int RAD_W   = 2 * LEVEL_W;
  localparam int SREM_W  = LEVEL_W + 1;

  // Sampling grid
  localparam int SAMPLE_STEP_DEF = 10;
  localparam int MAX_DIM         = 2048;
  localparam int MAX_DIM_W       = 13;

  // Register reset values, Q9.8, then saturation limits
  localparam logic [LEVEL_W-1:0] FLOOR_RESET = 17'd2560;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 17'd112896;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX     = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // Iteration counts of the shared step counter
  localparam int SQRT_STEPS = LEVEL_W;
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // Running level update: (9 * old + new) / 10 by reciprocal multiply
  localparam int EMA_DIV     = 10;
  localparam int BLEND_W     = LEVEL_W + 5;
  localparam int EMA_SHIFT   = BLEND_W + $clog2(EMA_DIV) + 1;
  localparam int EMA_RECIP_W = EMA_SHIFT - $clog2(EMA_DIV) + 1;
  localparam int EMA_PROD_W  = BLEND_W + EMA_RECIP_W;
  localparam logic [EMA_RECIP_W-1:0] EMA_RECIP =
    EMA_RECIP_W'(((64'd1 << EMA_SHIFT) + 64'(EMA_DIV) - 64'd1) / 64'(EMA_DIV));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_FLOOR   = 1'b0,
    REG_INITIAL_LEVEL = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SQRT,
    S_ACCUM,
    S_FRAME,
    S_DIV,
    S_CLAMP,
    S_BLEND,
    S_SCALE
  } state_t;

  typedef struct packed {
    logic restore;
    logic sqrt_load;
    logic sqrt_step;
    logic accum;
    logic pick_floor;
    logic div_load;
    logic div_step;
    logic clamp;
    logic blend;
    logic scale;
  } ctrl_cmd_t;

  typedef struct packed {
    logic restore_req;
    logic sampled;
    logic last;
    logic count_zero;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/fnle_pix_if.sv */
interface fnle_pix_if;
  import fnle_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [PIX_W-1:0]   cur_blue;
  logic [PIX_W-1:0]   cur_green;
  logic [PIX_W-1:0]   cur_red;
  logic [PIX_W-1:0]   prev_blue;
  logic [PIX_W-1:0]   prev_green;
  logic [PIX_W-1:0]   prev_red;
  logic               frame_end;

  modport source (
    output valid, mode, column, row, cur_blue, cur_green, cur_red,
           prev_blue, prev_green, prev_red, frame_end,
    input  ready
  );

  modport sink (
    input  valid, mode, column, row, cur_blue, cur_green, cur_red,
           prev_blue, prev_green, prev_red, frame_end,
    output ready
  );
endinterface

/* src/fnle_res_if.sv */
interface fnle_res_if;
  import fnle_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] noise_level;
  logic [LEVEL_W-1:0] frame_noise;
  logic [COUNT_W-1:0] sample_count;

  modport source (
    output valid, noise_level, frame_noise, sample_count,
    input  ready
  );

  modport sink (
    input  valid, noise_level, frame_noise, sample_count,
    output ready
  );
endinterface

/* src/fnle_cfg_if.sv */
interface fnle_cfg_if;
  import fnle_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* src/fnle_ctrl.sv */
module fnle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  fnle_pix_if.sink             pix,
  input  fnle_pkg::dp_stat_t   stat,
  output fnle_pkg::ctrl_cmd_t  cmd
);
  import fnle_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  sqrt_last;
  logic                  div_last;
  logic                  pass_on;
  logic                  take;

  assign sqrt_last = (step_cnt == STEP_CNT_W'(SQRT_STEPS - 1));
  assign div_last  = (step_cnt == STEP_CNT_W'(DIV_STEPS - 1));

  // A mode 1 word, or one that needs no square root and ends no frame, frees the input at once
  assign pass_on = stat.restore_req || (!stat.sampled && !stat.last);
  assign take    = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if ((state == S_SQRT && !sqrt_last) || (state == S_DIV && !div_last)) begin
        step_cnt <= step_cnt + 1'b1;
      end else begin
        step_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (pass_on) begin
          state_next = take ? S_DECIDE : S_IDLE;
        end else if (stat.sampled) begin
          state_next = S_SQRT;
        end else begin
          state_next = S_FRAME;
        end
      end
      S_SQRT: begin
        if (sqrt_last) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        state_next = stat.last ? S_FRAME : S_IDLE;
      end
      S_FRAME: begin
        state_next = stat.count_zero ? S_BLEND : S_DIV;
      end
      S_DIV: begin
        if (div_last) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        state_next = S_BLEND;
      end
      S_BLEND: begin
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    pix.ready = 1'b0;
    case (state)
      S_IDLE: begin
        pix.ready = 1'b1;
      end
      S_DECIDE: begin
        pix.ready     = pass_on;
        cmd.restore   = stat.restore_req;
        cmd.sqrt_load = !stat.restore_req && stat.sampled;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
      end
      S_FRAME: begin
        cmd.pick_floor = stat.count_zero;
        cmd.div_load   = !stat.count_zero;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
      end
      S_BLEND: begin
        cmd.blend = 1'b1;
      end
      S_SCALE: begin
        cmd.scale = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
    // Take no word while reset is held
    if (rst) begin
      pix.ready = 1'b0;
    end
  end

  a_take_decides: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_DECIDE)
    else $error("accepted word not followed by decision cycle");

  a_ready_only_free: assert property (@(posedge clk) disable iff (rst)
    pix.ready |-> (state == S_IDLE || state == S_DECIDE))
    else $error("input ready while a word is still in work");

  a_sqrt_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && sqrt_last) |=> state == S_ACCUM)
    else $error("square root did not end in accumulate");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_last) |=> state == S_CLAMP)
    else $error("division did not end in clamp");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sqrt_step, cmd.div_step, cmd.accum, cmd.blend, cmd.scale,
              cmd.restore, cmd.div_load, cmd.pick_floor}))
    else $error("more than one datapath operation at once");

endmodule

/* src/fnle_dp.sv */
module fnle_dp #(
  parameter int SAMPLE_STEP = fnle_pkg::SAMPLE_STEP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fnle_pkg::ctrl_cmd_t  cmd,
  output fnle_pkg::dp_stat_t   stat,
  fnle_pix_if.sink             pix,
  fnle_res_if.source           res,
  fnle_cfg_if.sink             cfg
);
  import fnle_pkg::*;

  // Coordinate / SAMPLE_STEP by reciprocal multiply, exact over the coordinate range
  localparam int GRID_SHIFT   = COORD_W + $clog2(SAMPLE_STEP) + 1;
  localparam int GRID_RECIP_W = GRID_SHIFT + 1;
  localparam int GRID_PROD_W  = COORD_W + GRID_RECIP_W;
  localparam logic [GRID_RECIP_W-1:0] GRID_RECIP =
    GRID_RECIP_W'(((64'd1 << GRID_SHIFT) + 64'(SAMPLE_STEP) - 64'd1) / 64'(SAMPLE_STEP));
  localparam int STEP_W       = $clog2(SAMPLE_STEP + 1);
  localparam int CHECK_W      = COORD_W + STEP_W;

  // Configuration and running state
  logic [LEVEL_W-1:0]     noise_floor;
  logic [LEVEL_W-1:0]     initial_level;
  logic [SUM_W-1:0]       distance_sum;
  logic [COUNT_W-1:0]     sample_total;
  logic [LEVEL_W-1:0]     running_level;
  logic                   out_valid;

  // Captured word
  logic                   mode;
  logic                   last;
  logic [COORD_W-1:0]     column;
  logic [COORD_W-1:0]     row;
  logic [COORD_W-1:0]     column_quot;
  logic [COORD_W-1:0]     row_quot;
  logic [SUMSQ_W-1:0]     sumsq;

  // Iteration registers
  logic [RAD_W-1:0]       rad;
  logic [SREM_W-1:0]      srem;
  logic [LEVEL_W-1:0]     sroot;
  logic [SUM_W-1:0]       dquot;
  logic [COUNT_W-1:0]     drem;
  logic [LEVEL_W-1:0]     frame_noise;
  logic [BLEND_W-1:0]     blend_sum;

  // Output register
  logic [LEVEL_W-1:0]     out_level;
  logic [LEVEL_W-1:0]     out_noise;
  logic [COUNT_W-1:0]     out_count;

  logic                   take;
  logic [PIX_W-1:0]       diff_b;
  logic [PIX_W-1:0]       diff_g;
  logic [PIX_W-1:0]       diff_r;
  logic [SUMSQ_W-1:0]     sumsq_next;
  logic [COORD_W-1:0]     column_quot_next;
  logic [COORD_W-1:0]     row_quot_next;
  logic                   on_grid;
  logic                   in_range;
  logic [SREM_W+1:0]      s_cand;
  logic [SREM_W+1:0]      s_trial;
  logic                   s_fit;
  logic [COUNT_W:0]       d_cand;
  logic                   d_fit;
  logic [SUM_W:0]         sum_wide;
  logic [LEVEL_W-1:0]     mean_sat;
  logic [EMA_PROD_W-1:0]  ema_prod;
  logic [LEVEL_W-1:0]     running_level_next;

  assign take = pix.valid && pix.ready;

  always_comb begin
    diff_b = (pix.cur_blue > pix.prev_blue) ? pix.cur_blue - pix.prev_blue
                                            : pix.prev_blue - pix.cur_blue;
    diff_g = (pix.cur_green > pix.prev_green) ? pix.cur_green - pix.prev_green
                                              : pix.prev_green - pix.cur_green;
    diff_r = (pix.cur_red > pix.prev_red) ? pix.cur_red - pix.prev_red
                                          : pix.prev_red - pix.cur_red;
    sumsq_next = SUMSQ_W'(diff_b * diff_b) + SUMSQ_W'(diff_g * diff_g)
               + SUMSQ_W'(diff_r * diff_r);
    column_quot_next = COORD_W'((GRID_PROD_W'(pix.column) * GRID_PROD_W'(GRID_RECIP))
                                >> GRID_SHIFT);
    row_quot_next    = COORD_W'((GRID_PROD_W'(pix.row) * GRID_PROD_W'(GRID_RECIP))
                                >> GRID_SHIFT);
  end

  // Sampled when quotient times step gives the coordinate back and both coordinates are below MAX_DIM
  always_comb begin
    on_grid = (CHECK_W'(column_quot) * CHECK_W'(SAMPLE_STEP) == CHECK_W'(column))
           && (CHECK_W'(row_quot) * CHECK_W'(SAMPLE_STEP) == CHECK_W'(row));
    in_range = (MAX_DIM_W'(column) < MAX_DIM_W'(MAX_DIM))
            && (MAX_DIM_W'(row) < MAX_DIM_W'(MAX_DIM));
  end

  always_comb begin
    stat.restore_req = mode;
    stat.sampled     = on_grid && in_range;
    stat.last        = last;
    stat.count_zero  = (sample_total == '0);
    stat.out_free    = !out_valid || res.ready;
  end

  // One root bit per step
  always_comb begin
    s_cand  = {srem, rad[RAD_W-1 -: 2]};
    s_trial = {1'b0, sroot, 2'b01};
    s_fit   = (s_cand >= s_trial);
  end

  // One quotient bit per step
  always_comb begin
    d_cand = {drem, dquot[SUM_W-1]};
    d_fit  = (d_cand >= {1'b0, sample_total});
  end

  always_comb begin
    sum_wide           = {1'b0, distance_sum} + (SUM_W + 1)'(sroot);
    mean_sat           = (dquot[SUM_W-1:LEVEL_W] != '0) ? LEVEL_MAX : dquot[LEVEL_W-1:0];
    ema_prod           = EMA_PROD_W'(blend_sum) * EMA_PROD_W'(EMA_RECIP);
    running_level_next = LEVEL_W'(ema_prod >> EMA_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor   <= FLOOR_RESET;
      initial_level <= LEVEL_RESET;
      distance_sum  <= '0;
      sample_total  <= '0;
      running_level <= LEVEL_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_NOISE_FLOOR:   noise_floor   <= LEVEL_W'(cfg.data);
          REG_INITIAL_LEVEL: initial_level <= LEVEL_W'(cfg.data);
          default: begin
          end
        endcase
      end
      if (cmd.restore) begin
        running_level <= initial_level;
      end
      if (cmd.accum) begin
        distance_sum <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        if (sample_total != COUNT_MAX) begin
          sample_total <= sample_total + 1'b1;
        end
      end
      if (cmd.scale) begin
        running_level <= running_level_next;
        distance_sum  <= '0;
        sample_total  <= '0;
        out_valid     <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode        <= pix.mode;
      last        <= pix.frame_end;
      column      <= pix.column;
      row         <= pix.row;
      column_quot <= column_quot_next;
      row_quot    <= row_quot_next;
      sumsq       <= sumsq_next;
    end
    if (cmd.sqrt_load) begin
      rad   <= {sumsq, (RAD_W - SUMSQ_W)'(0)};
      srem  <= '0;
      sroot <= '0;
    end else if (cmd.sqrt_step) begin
      rad   <= {rad[RAD_W-3:0], 2'b00};
      srem  <= s_fit ? SREM_W'(s_cand - s_trial) : SREM_W'(s_cand);
      sroot <= {sroot[LEVEL_W-2:0], s_fit};
    end
    if (cmd.div_load) begin
      dquot <= distance_sum;
      drem  <= '0;
    end else if (cmd.div_step) begin
      dquot <= {dquot[SUM_W-2:0], d_fit};
      drem  <= d_fit ? COUNT_W'(d_cand - {1'b0, sample_total}) : COUNT_W'(d_cand);
    end
    if (cmd.pick_floor) begin
      frame_noise <= noise_floor;
    end else if (cmd.clamp) begin
      frame_noise <= (mean_sat < noise_floor) ? noise_floor : mean_sat;
    end
    if (cmd.blend) begin
      blend_sum <= (BLEND_W'(running_level) << 3) + BLEND_W'(running_level)
                 + BLEND_W'(frame_noise);
    end
    if (cmd.scale) begin
      out_level <= running_level_next;
      out_noise <= frame_noise;
      out_count <= sample_total;
    end
  end

  assign cfg.ready        = !rst;
  assign res.valid        = out_valid;
  assign res.noise_level  = out_level;
  assign res.frame_noise  = out_noise;
  assign res.sample_count = out_count;

endmodule

/* src/frame_noise_level_estimator_core.sv */
// Frame noise level estimator.
// pix carries one word per pixel: current and previous colour, column, row and a
// frame_end flag; mode 1 instead reloads the running level from initial_level.
// res carries one word per frame, on the mode 0 word flagged frame_end: the updated
// running level, the frame's floored mean distance and its sample count.
// cfg writes noise_floor (index 0) and initial_level (index 1); write it only
// while no pixel word is in work. It is ready whenever reset is low.
// Timing: a pixel off the sampling grid, or a mode 1 word, frees the input in
// its decision state, so such words stream at one per clock. A sampled pixel
// holds the input through the decision state, the 17 steps of the bit-serial
// square root and the accumulate state. An unsampled frame_end word runs the
// frame state, the 33 steps of the divider, clamp, blend and scale, which loads
// the output register; the next word is taken once the block is idle again.
// A sampled frame_end word runs the square root and accumulate first. With count
// zero the divider and clamp are skipped and the floor is used, frame to blend.
// A stalled receiver holds the result in the output register; the input keeps
// taking words until the next frame's result is ready to load, then waits.
// Reset empties the output register, clears sum and count, and restores the
// register and level reset values; no word is taken while it is held.
module frame_noise_level_estimator_core #(
  parameter int SAMPLE_STEP = fnle_pkg::SAMPLE_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fnle_pix_if.sink    pix,
  fnle_res_if.source  res,
  fnle_cfg_if.sink    cfg
);
  import fnle_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  fnle_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix),
    .stat (stat),
    .cmd  (cmd)
  );

  fnle_dp #(
    .SAMPLE_STEP (SAMPLE_STEP)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .pix  (pix),
    .res  (res),
    .cfg  (cfg)
  );

endmodule
